// File: sv/epoc_pkg.sv
// Shared types and constants for the exact pattern occurrence counter.
package epoc_pkg;

   // Defaults for the top-level parameters
   localparam int DEFAULT_MAX_PATTERN   = 32;
   localparam int DEFAULT_POSITION_BITS = 32;

   // Register file shape
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 64;
   localparam int PAT_LEN_W   = 6;
   localparam int PAT_WORDS   = 4;
   localparam int PAT_BYTES   = PAT_WORDS * 8;
   localparam int PAT_IDX_W   = $clog2(PAT_BYTES);

   // Internal length width, enough for lengths up to 64
   localparam int LEN_W = 7;

   // Result field widths
   localparam int START_W = 32;
   localparam int TOTAL_W = 32;

   // Register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PATTERN_LEN    = 3'd0,
      CSR_PAT_BYTES_0_7  = 3'd1,
      CSR_PAT_BYTES_8_15 = 3'd2,
      CSR_PAT_BYTES_16_23 = 3'd3,
      CSR_PAT_BYTES_24_31 = 3'd4
   } csr_index_type;

   // Input word
   typedef struct packed {
      logic [7:0] text_byte;
      logic       last;
   } req_word_type;

   // Result word
   typedef struct packed {
      logic               match;
      logic [START_W-1:0] match_start;
      logic [TOTAL_W-1:0] match_total;
   } rsp_word_type;

endpackage

// File: sv/exact_pattern_occurrence_counter_core.sv
// Top level of the exact pattern occurrence counter.
// Text bytes stream in one word per cycle; every accepted word yields exactly one
// result word, passing through the input register and then a single full-window
// compare into the result register, and a new word is taken every cycle as long as
// the result side keeps up. Totals saturate. The whole window of up to MAX_PATTERN
// bytes is compared in parallel against a registered pattern image, re-aligned to
// the configured length after each register write. A word with last set gets its
// normal result and then clears history, position and total for the next text.
module exact_pattern_occurrence_counter_core #(
   parameter int MAX_PATTERN   = epoc_pkg::DEFAULT_MAX_PATTERN,
   parameter int POSITION_BITS = epoc_pkg::DEFAULT_POSITION_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  epoc_pkg::req_word_type             req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output epoc_pkg::rsp_word_type             rsp_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [epoc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [epoc_pkg::CSR_DATA_W-1:0]    csr_data
);

   localparam int HIST_DEPTH = (MAX_PATTERN > 1) ? MAX_PATTERN - 1 : 1;
   localparam int START_WIDE = (POSITION_BITS > epoc_pkg::START_W) ?
                               POSITION_BITS : epoc_pkg::START_W;

   logic [MAX_PATTERN*8-1:0]       aligned;
   logic [MAX_PATTERN-1:0]         mask;
   logic [epoc_pkg::LEN_W-1:0]     len_m1;

   logic                           s1_valid_ff;
   epoc_pkg::req_word_type         s1_word_ff;
   logic                           rsp_valid_ff;
   epoc_pkg::rsp_word_type         rsp_word_ff;
   epoc_pkg::rsp_word_type         rsp_word_in;

   logic [7:0]                     hist_ff [HIST_DEPTH];
   logic [POSITION_BITS-1:0]       pos_ff;
   logic [epoc_pkg::TOTAL_W-1:0]   count_ff;
   logic [epoc_pkg::TOTAL_W-1:0]   count_in;

   logic                           advance;
   logic [MAX_PATTERN*8-1:0]       window;
   logic [MAX_PATTERN-1:0]         slot_ok;
   logic                           hit;
   logic [POSITION_BITS-1:0]       len_m1_ext;
   logic [START_WIDE-1:0]          start_wide;

   // Pattern registers and alignment
   epoc_pattern #(
      .MAX_PATTERN (MAX_PATTERN)
   ) u_pattern (
      .clock      (clock),
      .reset      (reset),
      .csr_write  (csr_valid & csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .aligned_ff (aligned),
      .mask_ff    (mask),
      .len_m1_ff  (len_m1)
   );

   assign csr_ready = 1'b1;

   // Advance when a word waits and the result register is free or being taken
   assign advance   = s1_valid_ff & (~rsp_valid_ff | rsp_ready);
   assign req_ready = ~s1_valid_ff | advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_word_ff;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         s1_word_ff <= req_data;
      end
   end

   // Build the window, newest byte in slot 0, and compare every slot in use
   always_comb begin
      window         = '0;
      window[7:0]    = s1_word_ff.text_byte;
      for (int j = 1; j < MAX_PATTERN; j++) begin
         window[j*8 +: 8] = hist_ff[j-1];
      end
      for (int j = 0; j < MAX_PATTERN; j++) begin
         slot_ok[j] = ~mask[j] | (window[j*8 +: 8] == aligned[j*8 +: 8]);
      end
      len_m1_ext = POSITION_BITS'(len_m1);
      hit        = (&slot_ok) & (pos_ff >= len_m1_ext);
   end

   // Form the result word
   always_comb begin
      start_wide = START_WIDE'(pos_ff - len_m1_ext);
      count_in   = count_ff;
      if (hit && count_ff != '1) begin
         count_in = count_ff + epoc_pkg::TOTAL_W'(1);
      end
      rsp_word_in.match       = hit;
      rsp_word_in.match_start = hit ? start_wide[epoc_pkg::START_W-1:0] : '0;
      rsp_word_in.match_total = count_in;
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   // Update history, position and total; last clears them for the next text
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         count_ff <= '0;
         for (int k = 0; k < HIST_DEPTH; k++) begin
            hist_ff[k] <= '0;
         end
      end else if (advance) begin
         if (s1_word_ff.last) begin
            pos_ff   <= '0;
            count_ff <= '0;
            for (int k = 0; k < HIST_DEPTH; k++) begin
               hist_ff[k] <= '0;
            end
         end else begin
            count_ff <= count_in;
            if (pos_ff != '1) begin
               pos_ff <= pos_ff + POSITION_BITS'(1);
            end
            hist_ff[0] <= s1_word_ff.text_byte;
            for (int k = 1; k < HIST_DEPTH; k++) begin
               hist_ff[k] <= hist_ff[k-1];
            end
         end
      end
   end

endmodule

// File: sv/epoc_pattern.sv
// Pattern registers and the length-aligned pattern window they produce.
module epoc_pattern #(
   parameter int MAX_PATTERN = epoc_pkg::DEFAULT_MAX_PATTERN
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_write,
   input  logic [epoc_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [epoc_pkg::CSR_DATA_W-1:0]        csr_data,
   output logic [MAX_PATTERN*8-1:0]               aligned_ff,
   output logic [MAX_PATTERN-1:0]                 mask_ff,
   output logic [epoc_pkg::LEN_W-1:0]             len_m1_ff
);

   logic [epoc_pkg::PAT_LEN_W-1:0]              pattern_len_ff;
   logic [epoc_pkg::PAT_BYTES*8-1:0]            pattern_ff;
   logic [MAX_PATTERN*8-1:0]                    aligned_in;
   logic [MAX_PATTERN-1:0]                      mask_in;
   logic [epoc_pkg::LEN_W-1:0]                  len_m1_in;
   logic [epoc_pkg::LEN_W-1:0]                  len_act;
   logic [epoc_pkg::LEN_W-1:0]                  idx;

   // Decode register writes; unknown indexes drop the write
   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_len_ff <= epoc_pkg::PAT_LEN_W'(1);
         pattern_ff     <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            epoc_pkg::CSR_PATTERN_LEN: begin
               pattern_len_ff <= csr_data[epoc_pkg::PAT_LEN_W-1:0];
            end
            epoc_pkg::CSR_PAT_BYTES_0_7: begin
               pattern_ff[0*epoc_pkg::CSR_DATA_W +: epoc_pkg::CSR_DATA_W] <= csr_data;
            end
            epoc_pkg::CSR_PAT_BYTES_8_15: begin
               pattern_ff[1*epoc_pkg::CSR_DATA_W +: epoc_pkg::CSR_DATA_W] <= csr_data;
            end
            epoc_pkg::CSR_PAT_BYTES_16_23: begin
               pattern_ff[2*epoc_pkg::CSR_DATA_W +: epoc_pkg::CSR_DATA_W] <= csr_data;
            end
            epoc_pkg::CSR_PAT_BYTES_24_31: begin
               pattern_ff[3*epoc_pkg::CSR_DATA_W +: epoc_pkg::CSR_DATA_W] <= csr_data;
            end
            default: begin
            end
         endcase
      end
   end

   // Clamp the length into 1..MAX_PATTERN
   always_comb begin
      if (pattern_len_ff == '0) begin
         len_act = epoc_pkg::LEN_W'(1);
      end else if (epoc_pkg::LEN_W'(pattern_len_ff) > epoc_pkg::LEN_W'(MAX_PATTERN)) begin
         len_act = epoc_pkg::LEN_W'(MAX_PATTERN);
      end else begin
         len_act = epoc_pkg::LEN_W'(pattern_len_ff);
      end
      len_m1_in = len_act - epoc_pkg::LEN_W'(1);
   end

   // Align the pattern so that window slot 0 (newest byte) meets the last pattern byte
   always_comb begin
      idx        = '0;
      aligned_in = '0;
      mask_in    = '0;
      for (int j = 0; j < MAX_PATTERN; j++) begin
         idx        = len_m1_in - epoc_pkg::LEN_W'(j);
         mask_in[j] = epoc_pkg::LEN_W'(j) < len_act;
         if (mask_in[j] && idx < epoc_pkg::LEN_W'(epoc_pkg::PAT_BYTES)) begin
            aligned_in[j*8 +: 8] = pattern_ff[{idx[epoc_pkg::PAT_IDX_W-1:0], 3'b000} +: 8];
         end
      end
   end

   // Hold the aligned window for the compare stage
   always_ff @(posedge clock) begin
      if (reset) begin
         aligned_ff <= '0;
         mask_ff    <= MAX_PATTERN'(1);
         len_m1_ff  <= '0;
      end else begin
         aligned_ff <= aligned_in;
         mask_ff    <= mask_in;
         len_m1_ff  <= len_m1_in;
      end
   end

endmodule
